@@ rtl/core/vtgd_pkg.sv @@
// package for the vector tile geometry decoder
// holds command and phase codes, part counter sizing and the zigzag decode
// no dependencies
package vtgd_pkg;

    localparam int PART_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = WORD_W - CMD_W;
    localparam int INDEX_W   = 16;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [1:0]           t_phase;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [PART_BITS-1:0] t_part;

    localparam t_cmd CMD_NONE  = 3'd0;
    localparam t_cmd CMD_MOVE  = 3'd1;
    localparam t_cmd CMD_LINE  = 3'd2;
    localparam t_cmd CMD_CLOSE = 3'd7;

    localparam t_phase PH_CMD = 2'd0;
    localparam t_phase PH_X   = 2'd1;
    localparam t_phase PH_Y   = 2'd2;

    localparam t_part PART_MAX = '1;

    // zigzag: lsb carries the sign, the rest the magnitude
    function automatic t_word unzigzag(input t_word n);
        unzigzag = (n >> 1) ^ {WORD_W{n[0]}};
    endfunction

endpackage

@@ rtl/core/vtgd_if.sv @@
// valid/ready channel interfaces of the vector tile geometry decoder
// depends on vtgd_pkg for field widths
interface vtgd_word_if;
    logic                           valid;
    logic                           ready;
    logic [vtgd_pkg::WORD_W-1:0]    geom_word;
    logic                           first_word;

    modport source (output valid, output geom_word, output first_word, input ready);
    modport sink   (input valid, input geom_word, input first_word, output ready);
endinterface

interface vtgd_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [vtgd_pkg::WORD_W-1:0] point_x;
    logic signed [vtgd_pkg::WORD_W-1:0] point_y;
    logic [vtgd_pkg::INDEX_W-1:0]       part_index;
    logic                               is_close;

    modport source (output valid, output point_x, output point_y, output part_index,
                    output is_close, input ready);
    modport sink   (input valid, input point_x, input point_y, input part_index,
                    input is_close, output ready);
endinterface

@@ rtl/core/vector_tile_geometry_decoder_top.sv @@
// vector tile geometry decoder, top level and only module
// depends on vtgd_pkg and the channel interfaces in vtgd_if.sv
//
// usage
//   i_geom carries one 32-bit geometry word per transfer plus a first_word flag
//   that marks the start of a feature. command words hold the command in bits
//   2:0 and a repeat count above; moveto/lineto are followed by count pairs of
//   zigzag deltas. o_point carries one absolute vertex per completed pair and
//   one per closepath, with the part index and a close flag.
//   path: a word taken into the input register is decoded from there; its vertex,
//   if any, is loaded into the result register and from there shown on o_point.
//   throughput: one word per cycle unless a held word needs a blocked output slot,
//   set by the single decode stage that reads and updates the cursor state in the same cycle.
//   stall: the input register holds a word that needs the output slot while a
//   vertex waits unclaimed on o_point; i_geom.ready drops only when both registers
//   are full and the held word would need the output slot. ready depends on o_point.ready.
//   reset: synchronous active-low i_rst_n empties both registers and clears
//   cursor, start point, part counter and the pending command.
module vector_tile_geometry_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    vtgd_word_if.sink           i_geom,
    vtgd_point_if.source        o_point
);

    // input register
    logic                   r_in_valid;
    vtgd_pkg::t_word        r_in_word;
    logic                   r_in_first;

    // decoder state
    vtgd_pkg::t_phase       r_phase,  n_phase;
    vtgd_pkg::t_cmd         r_cmd,    n_cmd;
    vtgd_pkg::t_count       r_pairs,  n_pairs;
    vtgd_pkg::t_word        r_cur_x,  n_cur_x;
    vtgd_pkg::t_word        r_cur_y,  n_cur_y;
    vtgd_pkg::t_word        r_start_x, n_start_x;
    vtgd_pkg::t_word        r_start_y, n_start_y;
    vtgd_pkg::t_part        r_part,   n_part;

    // result register
    logic                   r_out_valid;
    vtgd_pkg::t_word        r_out_x,  n_out_x;
    vtgd_pkg::t_word        r_out_y,  n_out_y;
    logic                   r_out_close, n_out_close;
    logic [vtgd_pkg::INDEX_W-1:0] r_out_part;

    // state as seen by the held word (cleared when it opens a feature)
    vtgd_pkg::t_phase       w_phase;
    vtgd_pkg::t_cmd         w_cmd;
    vtgd_pkg::t_count       w_pairs;
    vtgd_pkg::t_word        w_cur_x, w_cur_y, w_start_x, w_start_y;
    vtgd_pkg::t_part        w_part;
    vtgd_pkg::t_word        w_delta;
    vtgd_pkg::t_cmd         w_word_cmd;
    vtgd_pkg::t_count       w_word_count;
    logic                   w_emit;
    logic                   w_advance;
    logic                   w_in_take;

    // the held word moves on when it needs no output slot or the slot frees up
    assign w_advance = r_in_valid && (!w_emit || !r_out_valid || o_point.ready);
    assign i_geom.ready = !r_in_valid || w_advance;
    assign w_in_take    = i_geom.valid && i_geom.ready;

    always_comb begin
        w_phase   = r_in_first ? vtgd_pkg::PH_CMD   : r_phase;
        w_cmd     = r_in_first ? vtgd_pkg::CMD_NONE : r_cmd;
        w_pairs   = r_in_first ? '0 : r_pairs;
        w_cur_x   = r_in_first ? '0 : r_cur_x;
        w_cur_y   = r_in_first ? '0 : r_cur_y;
        w_start_x = r_in_first ? '0 : r_start_x;
        w_start_y = r_in_first ? '0 : r_start_y;
        w_part    = r_in_first ? '0 : r_part;
    end

    assign w_delta      = vtgd_pkg::unzigzag(r_in_word);
    assign w_word_cmd   = r_in_word[vtgd_pkg::CMD_W-1:0];
    assign w_word_count = r_in_word[vtgd_pkg::WORD_W-1:vtgd_pkg::CMD_W];

    always_comb begin
        n_phase     = w_phase;
        n_cmd       = w_cmd;
        n_pairs     = w_pairs;
        n_cur_x     = w_cur_x;
        n_cur_y     = w_cur_y;
        n_start_x   = w_start_x;
        n_start_y   = w_start_y;
        n_part      = w_part;
        n_out_x     = w_start_x;
        n_out_y     = w_start_y;
        n_out_close = 1'b0;
        w_emit      = 1'b0;
        unique case (w_phase)
            vtgd_pkg::PH_X: begin
                n_cur_x = w_cur_x + w_delta;
                n_phase = vtgd_pkg::PH_Y;
            end
            vtgd_pkg::PH_Y: begin
                n_cur_y = w_cur_y + w_delta;
                if (w_cmd == vtgd_pkg::CMD_MOVE) begin
                    if (w_part != vtgd_pkg::PART_MAX) begin
                        n_part = w_part + 1'b1;
                    end
                    n_start_x = w_cur_x;
                    n_start_y = n_cur_y;
                end
                n_pairs = w_pairs - 1'b1;
                n_phase = (n_pairs == '0) ? vtgd_pkg::PH_CMD : vtgd_pkg::PH_X;
                n_out_x = w_cur_x;
                n_out_y = n_cur_y;
                w_emit  = 1'b1;
            end
            default: begin
                // command word
                unique case (w_word_cmd) inside
                    vtgd_pkg::CMD_MOVE, vtgd_pkg::CMD_LINE: begin
                        n_cmd   = w_word_cmd;
                        n_pairs = w_word_count;
                        n_phase = (w_word_count == '0) ? vtgd_pkg::PH_CMD
                                                       : vtgd_pkg::PH_X;
                    end
                    vtgd_pkg::CMD_CLOSE: begin
                        n_phase     = vtgd_pkg::PH_CMD;
                        n_out_close = 1'b1;
                        w_emit      = 1'b1;
                    end
                    default: begin
                        // unknown command and its count are dropped
                        n_phase = vtgd_pkg::PH_CMD;
                    end
                endcase
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_in_word  <= i_geom.geom_word;
            r_in_first <= i_geom.first_word;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= vtgd_pkg::PH_CMD;
            r_cmd     <= vtgd_pkg::CMD_NONE;
            r_pairs   <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_part    <= '0;
        end else if (w_advance) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_pairs   <= n_pairs;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_part    <= n_part;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_emit) begin
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_close <= n_out_close;
            r_out_part  <= vtgd_pkg::INDEX_W'(n_part);
        end
    end

    assign o_point.valid      = r_out_valid;
    assign o_point.point_x    = $signed(r_out_x);
    assign o_point.point_y    = $signed(r_out_y);
    assign o_point.part_index = r_out_part;
    assign o_point.is_close   = r_out_close;

    // a pair in flight always has at least one pair left to finish
    a_pairs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == vtgd_pkg::PH_X || r_phase == vtgd_pkg::PH_Y) |-> (r_pairs != '0))
        else $error("pairs counter empty while a pair is pending");

    // the y half of a pair always yields a vertex
    a_y_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_phase == vtgd_pkg::PH_Y) |-> w_emit)
        else $error("y delta without a vertex");

    // a decoded vertex is presented on the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> r_out_valid)
        else $error("decoded vertex lost");

    // the part counter only grows inside a feature
    a_part_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in_first) |=> (r_part >= $past(r_part)))
        else $error("part counter went backwards");

    // input side stalls only with a word held and the output slot blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_geom.ready |-> (r_in_valid && r_out_valid && !o_point.ready))
        else $error("input stalled without cause");

endmodule
